/* design/iba_pkg.sv */
// Shared types and constants for the inode bitmap allocator.
package iba_pkg;

   // Operation codes carried in the request
   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0,
      OP_FREE  = 3'd1,
      OP_READ  = 3'd2,
      OP_WRITE = 3'd3,
      OP_ROOT  = 3'd4
   } opcode_type;

   // Status codes returned with every response
   typedef enum logic [2:0] {
      STAT_OK           = 3'd0,
      STAT_NONE_FREE    = 3'd1,
      STAT_OUT_OF_RANGE = 3'd2,
      STAT_ALREADY_FREE = 3'd3,
      STAT_NOT_ALLOC    = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_ACCESS,
      S_SCAN,
      S_FINISH
   } fsm_state_type;

   // Entry type bytes
   localparam logic [7:0] TYPE_UNUSED = 8'd0;
   localparam logic [7:0] TYPE_FILE   = 8'd1;
   localparam logic [7:0] TYPE_DIR    = 8'd2;

   // Field widths
   localparam int unsigned OPCODE_W = 3;
   localparam int unsigned INDEX_W  = 6;
   localparam int unsigned TYPE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned DATA_W   = 24;

   // Index fields reach 64 entries at most; count register reset value
   localparam int unsigned INDEX_REACH = 64;
   localparam logic [COUNT_W-1:0] ENTRIES_RESET = 7'd64;

   // Bitmap bits examined per scan step
   localparam int unsigned CHUNK_W = 8;

endpackage

/* design/inode_bitmap_allocator_core.sv */
// Top level: first-fit entry allocator with allocated bitmap and type memory.
// Free, read type, write type and root init go from access straight to finish; allocate adds
//   a bitmap scan of k = 1..ceil(min(POOL_DEPTH,64)/8) steps between them.
// The 8-bit-per-step bitmap scan sets the allocate time, and the request port is closed
//   while a request is at work, until its response is loaded.
// Reset clears the sequencer, the response valid and all allocated bits and sets the count
//   register to 64; the type memory is not cleared, since a free entry's type is never read.
module inode_bitmap_allocator_core #(
   parameter int unsigned POOL_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   // request: [2:0] opcode, [8:3] entry_index, [16:9] type_value, [23:17] zero
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [iba_pkg::DATA_W-1:0]   req_tdata,
   // response: [2:0] status, [8:3] result_index, [16:9] type_out, [23:17] zero
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [iba_pkg::DATA_W-1:0]   rsp_tdata,
   // entries_in_use register write
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [iba_pkg::COUNT_W-1:0]  csr_data
);
   import iba_pkg::*;

   // Entries reachable through the 6-bit index
   localparam int unsigned ACTIVE_DEPTH = (POOL_DEPTH < INDEX_REACH) ? POOL_DEPTH : INDEX_REACH;
   localparam int unsigned ADDR_W       = $clog2(ACTIVE_DEPTH);
   localparam int unsigned NUM_CHUNKS   = (ACTIVE_DEPTH + CHUNK_W - 1) / CHUNK_W;
   localparam int unsigned CHUNK_CNT_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int unsigned PAD_DEPTH    = NUM_CHUNKS * CHUNK_W;
   localparam logic [COUNT_W-1:0]     ACTIVE_CNT = COUNT_W'(ACTIVE_DEPTH);
   localparam logic [CHUNK_CNT_W-1:0] LAST_CHUNK = CHUNK_CNT_W'(NUM_CHUNKS - 1);

   fsm_state_type            state_ff, state_in;
   opcode_type               op_ff;
   logic [INDEX_W-1:0]       idx_ff;
   logic [TYPE_W-1:0]        tval_ff;
   logic [CHUNK_CNT_W-1:0]   chunk_ff, chunk_in;
   status_type               status_ff, status_in;
   logic [ADDR_W-1:0]        grant_ff, grant_in;
   logic [COUNT_W-1:0]       entries_ff;
   logic [ACTIVE_DEPTH-1:0]  alloc_ff;
   logic [TYPE_W-1:0]        rd_data_ff;
   logic                     rsp_tvalid_ff;
   logic [DATA_W-1:0]        rsp_tdata_ff;
   logic [TYPE_W-1:0]        type_mem [ACTIVE_DEPTH];

   logic                     req_accept;
   logic [COUNT_W-1:0]       active_cnt;
   logic                     in_range;
   logic                     is_alloc;
   logic [PAD_DEPTH-1:0]     alloc_pad;
   logic [CHUNK_W-1:0]       chunk_bits;
   logic [COUNT_W-1:0]       chunk_base;
   logic [COUNT_W-1:0]       cand_idx;
   logic                     hit;
   logic [ADDR_W-1:0]        hit_idx;
   logic                     alloc_set;
   logic                     alloc_clr;
   logic [ADDR_W-1:0]        alloc_addr;
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_addr;
   logic [TYPE_W-1:0]        mem_wdata;
   logic                     rsp_load;
   logic [INDEX_W-1:0]       rsp_index;
   logic [TYPE_W-1:0]        rsp_type;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Limit the count register to the pool
   assign active_cnt = (entries_ff > ACTIVE_CNT) ? ACTIVE_CNT : entries_ff;
   assign in_range   = ({1'b0, idx_ff} < active_cnt);
   assign is_alloc   = alloc_ff[idx_ff[ADDR_W-1:0]];

   // Pad the bitmap to whole chunks; padding reads as allocated
   for (genvar gi = 0; gi < PAD_DEPTH; gi++) begin : g_pad
      if (gi < ACTIVE_DEPTH) begin : g_bit
         assign alloc_pad[gi] = alloc_ff[gi];
      end else begin : g_fill
         assign alloc_pad[gi] = 1'b1;
      end
   end

   assign chunk_base = COUNT_W'(chunk_ff) << $clog2(CHUNK_W);
   assign chunk_bits = alloc_pad[chunk_base[$clog2(PAD_DEPTH)-1:0] +: CHUNK_W];

   // Priority encode the current chunk: lowest free entry below the active count
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      cand_idx = '0;
      for (int k = 0; k < CHUNK_W; k++) begin
         cand_idx = chunk_base + COUNT_W'(k);
         if (!hit && !chunk_bits[k] && (cand_idx < active_cnt)) begin
            hit     = 1'b1;
            hit_idx = ADDR_W'(cand_idx);
         end
      end
   end

   // Hold state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one request: access, scan for allocate, then load the response
   always_comb begin
      state_in   = state_ff;
      chunk_in   = chunk_ff;
      status_in  = status_ff;
      grant_in   = grant_ff;
      alloc_set  = 1'b0;
      alloc_clr  = 1'b0;
      alloc_addr = idx_ff[ADDR_W-1:0];
      mem_we     = 1'b0;
      mem_addr   = idx_ff[ADDR_W-1:0];
      mem_wdata  = tval_ff;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            state_in  = S_FINISH;
            status_in = STAT_OK;
            grant_in  = '0;
            chunk_in  = '0;
            unique case (op_ff)
               OP_ALLOC: begin
                  state_in = S_SCAN;
               end
               OP_FREE, OP_READ, OP_WRITE: begin
                  if (!in_range) begin
                     status_in = STAT_OUT_OF_RANGE;
                  end else if (!is_alloc) begin
                     status_in = (op_ff == OP_FREE) ? STAT_ALREADY_FREE : STAT_NOT_ALLOC;
                  end else if (op_ff == OP_FREE) begin
                     alloc_clr = 1'b1;
                     mem_we    = 1'b1;
                     mem_wdata = TYPE_UNUSED;
                  end else if (op_ff == OP_WRITE) begin
                     mem_we = 1'b1;
                  end
               end
               OP_ROOT: begin
                  alloc_addr = '0;
                  mem_addr   = '0;
                  mem_wdata  = TYPE_DIR;
                  if (active_cnt == '0) begin
                     status_in = STAT_OUT_OF_RANGE;
                  end else if (!alloc_ff[0]) begin
                     alloc_set = 1'b1;
                     mem_we    = 1'b1;
                  end
               end
               default: begin
                  status_in = STAT_OUT_OF_RANGE;
               end
            endcase
         end
         S_SCAN: begin
            alloc_addr = hit_idx;
            mem_addr   = hit_idx;
            mem_wdata  = TYPE_FILE;
            if (hit) begin
               alloc_set = 1'b1;
               mem_we    = 1'b1;
               grant_in  = hit_idx;
               status_in = STAT_OK;
               state_in  = S_FINISH;
            end else if (chunk_ff == LAST_CHUNK) begin
               status_in = STAT_NONE_FREE;
               state_in  = S_FINISH;
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Capture the request fields and working registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= opcode_type'(req_tdata[OPCODE_W-1:0]);
         idx_ff  <= req_tdata[OPCODE_W +: INDEX_W];
         tval_ff <= req_tdata[OPCODE_W+INDEX_W +: TYPE_W];
      end
      chunk_ff  <= chunk_in;
      status_ff <= status_in;
      grant_ff  <= grant_in;
   end

   // Write the count register
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
      end else if (csr_valid && csr_ready) begin
         entries_ff <= csr_data;
      end
   end

   // Set and clear allocated bits
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= '0;
      end else if (alloc_set) begin
         alloc_ff[alloc_addr] <= 1'b1;
      end else if (alloc_clr) begin
         alloc_ff[alloc_addr] <= 1'b0;
      end
   end

   // Type memory: one write port, registered read at the request index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         type_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= type_mem[idx_ff[ADDR_W-1:0]];
   end

   // Build response fields; zero them on failure
   assign rsp_index = (op_ff == OP_ALLOC && status_ff == STAT_OK) ? INDEX_W'(grant_ff) : '0;
   assign rsp_type  = (op_ff == OP_READ && status_ff == STAT_OK) ? rd_data_ff : '0;

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {{(DATA_W - STATUS_W - INDEX_W - TYPE_W){1'b0}},
                          rsp_type, rsp_index, status_ff};
      end
   end

`ifndef NO_ASSERTIONS
   // A granted entry is marked allocated by the time its response is built
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && op_ff == OP_ALLOC && status_ff == STAT_OK)
         |-> alloc_ff[grant_ff])
      else $error("granted entry not marked allocated");

   // A response appears only out of the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("response loaded outside finish step");

   // An accepted request closes the request port on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request port open while a request is at work");

   // A failed answer never carries an index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[STATUS_W-1:0] != STAT_OK)
         |-> rsp_tdata_ff[STATUS_W +: INDEX_W] == '0)
      else $error("failed response carries an index");
`endif

endmodule

/* bench/tb_inode_bitmap_allocator_core.sv */
// Self-checking testbench for the first-fit inode bitmap allocator core.
`timescale 1ns / 100ps

module tb_inode_bitmap_allocator_core;
   import iba_pkg::*;

   localparam int unsigned POOL_SIZE     = 64;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned HOLD_TRIGGER  = 500;

   // Opcodes the block does not implement
   localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;
   localparam logic [2:0] MID_UNUSED_OP   = 3'd6;
   localparam logic [2:0] LAST_UNUSED_OP  = 3'd7;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic [INDEX_W-1:0]  idx;
      logic [TYPE_W-1:0]   tval;
   } alloc_req_type;

   typedef struct packed {
      status_type          status;
      logic [INDEX_W-1:0]  index;
      logic [TYPE_W-1:0]   type_byte;
   } alloc_rsp_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [COUNT_W-1:0]   csr_data   = '0;

   // Shadow of the allocator state
   logic                 alloc_map [POOL_SIZE];
   logic [TYPE_W-1:0]    type_map  [POOL_SIZE];
   logic [COUNT_W-1:0]   count_shadow = ENTRIES_RESET;

   alloc_req_type        pending_reqs  [$];
   alloc_rsp_type        expected_rsps [$];
   int unsigned          items_popped = 0;
   int unsigned          results_seen = 0;
   int unsigned          failures     = 0;
   int unsigned          cycle_count  = 0;

   inode_bitmap_allocator_core #(
      .POOL_DEPTH (POOL_SIZE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Addressable entries for a given count register value
   function automatic int unsigned active_entries(input logic [COUNT_W-1:0] cnt);
      int unsigned n;
      n = 32'(cnt);
      if (n > POOL_SIZE) n = POOL_SIZE;
      if (n > INDEX_REACH) n = INDEX_REACH;
      return n;
   endfunction

   // Apply one request to the shadow state and queue the response it yields
   function automatic void predict_response(input alloc_req_type rq);
      alloc_rsp_type rsp;
      int unsigned   n;
      bit            found;
      n     = active_entries(count_shadow);
      rsp   = '{status: STAT_OK, index: '0, type_byte: '0};
      found = 1'b0;
      unique case (rq.op)
         OP_ALLOC: begin
            rsp.status = STAT_NONE_FREE;
            for (int unsigned i = 0; i < n; i++) begin
               if (!found && !alloc_map[i]) begin
                  found        = 1'b1;
                  alloc_map[i] = 1'b1;
                  type_map[i]  = TYPE_FILE;
                  rsp.index    = i[INDEX_W-1:0];
                  rsp.status   = STAT_OK;
               end
            end
         end
         OP_FREE, OP_READ, OP_WRITE: begin
            if (rq.idx >= n) begin
               rsp.status = STAT_OUT_OF_RANGE;
            end else if (!alloc_map[rq.idx]) begin
               rsp.status = (rq.op == OP_FREE) ? STAT_ALREADY_FREE : STAT_NOT_ALLOC;
            end else if (rq.op == OP_FREE) begin
               alloc_map[rq.idx] = 1'b0;
               type_map[rq.idx]  = TYPE_UNUSED;
            end else if (rq.op == OP_READ) begin
               rsp.type_byte = type_map[rq.idx];
            end else begin
               type_map[rq.idx] = rq.tval;
            end
         end
         OP_ROOT: begin
            if (n == 0) begin
               rsp.status = STAT_OUT_OF_RANGE;
            end else if (!alloc_map[0]) begin
               alloc_map[0] = 1'b1;
               type_map[0]  = TYPE_DIR;
            end
         end
         default: rsp.status = STAT_OUT_OF_RANGE;
      endcase
      expected_rsps.push_back(rsp);
   endfunction

   function automatic void push_req(input logic [OPCODE_W-1:0] op,
                                    input logic [INDEX_W-1:0] idx,
                                    input logic [TYPE_W-1:0] tval);
      pending_reqs.push_back('{op: op, idx: idx, tval: tval});
   endfunction

   // Random request, mostly aimed at the addressable low entries
   function automatic alloc_req_type random_req(input int unsigned n);
      alloc_req_type rq;
      int unsigned   pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      rq.op = OP_ALLOC;
      else if (pick < 55) rq.op = OP_FREE;
      else if (pick < 70) rq.op = OP_READ;
      else if (pick < 85) rq.op = OP_WRITE;
      else if (pick < 90) rq.op = OP_ROOT;
      else if (pick < 95) rq.op = OPCODE_W'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
      else                rq.op = OPCODE_W'($urandom_range(0, LAST_UNUSED_OP));
      if (n > 0 && $urandom_range(0, 3) != 0) rq.idx = INDEX_W'($urandom_range(0, n - 1));
      else                                    rq.idx = INDEX_W'($urandom_range(0, INDEX_REACH - 1));
      rq.tval = TYPE_W'($urandom_range(0, 255));
      return rq;
   endfunction

   // Wait until every request has been answered, then let the core settle
   task automatic wait_drained();
      while (!(pending_reqs.size() == 0 && results_seen == items_popped))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the entries-in-use register over the csr channel
   task automatic write_count(input logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      count_shadow  = value;
   endtask

   // Request driver: bursts of random length with random gaps
   int unsigned   burst_left = 1;
   int unsigned   gap_left   = 0;
   alloc_req_type held_req;

   always @(posedge clock) begin : req_driver
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_response(held_req);
         next_valid = req_tvalid && !req_tready;
         if (!next_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_reqs.size() != 0) begin
               held_req = pending_reqs.pop_front();
               items_popped++;
               req_tdata  <= {{(DATA_W - OPCODE_W - INDEX_W - TYPE_W){1'b0}},
                              held_req.tval, held_req.idx, held_req.op};
               next_valid = 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Response monitor and receiver stall pattern
   int unsigned hold_left  = 0;
   bit          hold_done  = 1'b0;
   int unsigned mode_left  = 0;
   int unsigned stall_mode = 0;

   always @(posedge clock) begin : rsp_monitor
      alloc_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         // check the accepted response against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_rsps.size() == 0) begin
               $error("unexpected response: tdata %h", rsp_tdata);
               failures++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tdata[2:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[2:0]);
                  failures++;
               end
               if (rsp_tdata[8:3] !== want.index) begin
                  $error("result_index: expected %0d, got %0d", want.index, rsp_tdata[8:3]);
                  failures++;
               end
               if (rsp_tdata[16:9] !== want.type_byte) begin
                  $error("type_out: expected %0d, got %0d", want.type_byte, rsp_tdata[16:9]);
                  failures++;
               end
            end
         end
         // hold off once for a long stretch, otherwise stall by mode
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(16, 80);
            end else begin
               mode_left--;
            end
            unique case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Stimulus sequence
   initial begin : stimulus
      logic [COUNT_W-1:0] plan [$];
      int unsigned        n;
      int unsigned        items;
      for (int i = 0; i < POOL_SIZE; i++) begin
         alloc_map[i] = 1'b0;
         type_map[i]  = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset count, every operation and each error path but none-free
      push_req(OP_READ, 6'd0, 8'd0);
      push_req(OP_FREE, 6'd0, 8'd0);
      push_req(OP_WRITE, 6'd63, 8'hFF);
      push_req(OP_ROOT, 6'd0, 8'd0);
      push_req(OP_ROOT, 6'd0, 8'd0);
      push_req(OP_READ, 6'd0, 8'd0);
      push_req(OP_ALLOC, 6'd0, 8'd0);
      push_req(OP_ALLOC, 6'd63, 8'hFF);
      push_req(OP_WRITE, 6'd1, 8'hFF);
      push_req(OP_READ, 6'd1, 8'd0);
      push_req(OP_WRITE, 6'd1, 8'd0);
      push_req(OP_READ, 6'd1, 8'd0);
      push_req(OP_FREE, 6'd1, 8'd0);
      push_req(OP_FREE, 6'd1, 8'd0);
      push_req(OP_ALLOC, 6'd0, 8'd0);
      push_req(FIRST_UNUSED_OP, 6'd0, 8'd0);
      push_req(MID_UNUSED_OP, 6'd63, 8'hFF);
      push_req(LAST_UNUSED_OP, 6'd21, 8'h5A);
      push_req(OP_READ, 6'd63, 8'd0);
      wait_drained();

      // directed: zero active count
      write_count(7'd0);
      push_req(OP_ALLOC, 6'd0, 8'd0);
      push_req(OP_ROOT, 6'd0, 8'd0);
      push_req(OP_FREE, 6'd0, 8'd0);
      push_req(OP_READ, 6'd0, 8'd0);
      wait_drained();

      // directed: single entry, lowered count hides entries 1 and 2
      write_count(7'd1);
      push_req(OP_ALLOC, 6'd0, 8'd0);
      push_req(OP_READ, 6'd1, 8'd0);
      push_req(OP_FREE, 6'd0, 8'd0);
      push_req(OP_ALLOC, 6'd0, 8'd0);
      wait_drained();

      // random phases across register settings
      plan = '{7'd127, 7'd64, 7'd8, 7'd0, 7'd1, 7'd33, 7'd2,
               COUNT_W'($urandom_range(1, 64)), 7'd64, COUNT_W'($urandom_range(65, 127))};
      foreach (plan[p]) begin
         write_count(plan[p]);
         n     = active_entries(plan[p]);
         items = (n == 0) ? 20 : 100;
         // fill the whole pool once so high indices and none-free show up
         if (p == 1) begin
            repeat (n + 2) push_req(OP_ALLOC, INDEX_W'($urandom_range(0, 63)),
                                    TYPE_W'($urandom_range(0, 255)));
         end
         repeat (items) pending_reqs.push_back(random_req(n));
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d expected responses never arrived", expected_rsps.size());
         failures++;
      end
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* inode_bitmap_allocator_core.f */
design/iba_pkg.sv
design/inode_bitmap_allocator_core.sv
bench/tb_inode_bitmap_allocator_core.sv
